FILE: sv/ntcb_pkg.sv
// ntcb_pkg: shared types, constants and the log2 fraction table function
package ntcb_pkg;

	localparam int LOG_TABLE_BITS_DEF  = 10;
	localparam int RATIO_FRAC_BITS_DEF = 16;

	localparam int V_W      = 13;
	localparam int SUP_W    = 13;
	localparam int OHM_W    = 20;
	localparam int BETA_W   = 14;
	localparam int T0_W     = 16;
	localparam int TEMP_W   = 16;
	localparam int ST_W     = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 20;

	localparam int RNUM_W   = 33;
	localparam int RDEN_W   = 33;
	localparam int E_W      = 6;
	localparam int LOG2_FRAC = 24;
	localparam int LMAG_W   = 30;
	localparam int PT_W     = 46;
	localparam int TDEN_W   = 48;
	localparam int KDEN_W   = 47;
	localparam int KNUM_W   = 62;
	localparam int KQ_W     = 17;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam int ZERO_C_CENTIK = 27315;
	localparam int OUT_MAX       = 32767;
	localparam int TK_MAX        = OUT_MAX + ZERO_C_CENTIK;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUPPLY  = 3'd0,
		REG_SERIES  = 3'd1,
		REG_NOMINAL = 3'd2,
		REG_BETA    = 3'd3,
		REG_REF_T   = 3'd4
	} cfg_reg_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_SAT     = 2'd2
	} status_t;

	typedef struct packed {
		logic inv;
		logic dz;
		logic sat;
	} flags_t;

	function automatic logic [LOG2_FRAC-1:0] log2_frac(input int i, input int lb);
		logic [63:0] x;
		logic [LOG2_FRAC-1:0] r;
		x = ((64'd1 << lb) + 64'(i)) << (30 - lb);
		r = '0;
		for (int b = LOG2_FRAC - 1; b >= 0; b--) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				r[b] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/ntcb_in_if.sv
// ntcb_in_if: sample channel carrying one divider voltage
interface ntcb_in_if;
	import ntcb_pkg::*;
	logic             valid;
	logic             ready;
	logic [V_W-1:0]   tap_mv;
	modport source (output valid, output tap_mv, input ready);
	modport sink   (input valid, input tap_mv, output ready);
endinterface

FILE: sv/ntcb_out_if.sv
// ntcb_out_if: result channel carrying temperature and status
interface ntcb_out_if;
	import ntcb_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp_centi_c;
	logic [ST_W-1:0]          status;
	modport source (output valid, output temp_centi_c, output status, input ready);
	modport sink   (input valid, input temp_centi_c, input status, output ready);
endinterface

FILE: sv/ntcb_div.sv
// ntcb_div: pipelined restoring divider, one quotient bit per stage
module ntcb_div import ntcb_pkg::*; #(
	parameter int DEN_W = RDEN_W,
	parameter int Q_W   = RNUM_W + RATIO_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [DEN_W-1:0] in_rem,
	input  logic [Q_W-1:0]   in_lo,
	input  logic [DEN_W-1:0] in_den,
	input  flags_t           in_fl,
	output logic             out_vld,
	output logic [Q_W-1:0]   out_q,
	output flags_t           out_fl
);

	logic             vld_s [Q_W];
	logic [DEN_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   wk_s  [Q_W];
	flags_t           fl_s  [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_st
		logic             vld_i;
		logic [DEN_W-1:0] rem_i;
		logic [DEN_W-1:0] den_i;
		logic [Q_W-1:0]   wk_i;
		flags_t           fl_i;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_i = in_vld;
			assign rem_i = in_rem;
			assign den_i = in_den;
			assign wk_i  = in_lo;
			assign fl_i  = in_fl;
		end else begin : g_next
			assign vld_i = vld_s[k-1];
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign wk_i  = wk_s[k-1];
			assign fl_i  = fl_s[k-1];
		end

		assign trial = {rem_i, wk_i[Q_W-1]};
		assign ge    = trial >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
				den_s[k] <= den_i;
				wk_s[k]  <= {wk_i[Q_W-2:0], ge};
				fl_s[k]  <= fl_i;
			end
		end
	end

	assign out_vld = vld_s[Q_W-1];
	assign out_q   = wk_s[Q_W-1];
	assign out_fl  = fl_s[Q_W-1];

endmodule

FILE: sv/ntcb_log.sv
// ntcb_log: leading-one search, log2 fraction table and ln2 scaling
module ntcb_log import ntcb_pkg::*; #(
	parameter int LOG_TABLE_BITS  = LOG_TABLE_BITS_DEF,
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
	parameter int QW              = RNUM_W + RATIO_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [QW-1:0]     in_q,
	input  flags_t            in_fl,
	output logic              out_vld,
	output logic [LMAG_W-1:0] ln_mag,
	output logic              ln_neg,
	output flags_t            out_fl
);

	localparam int NCH = (QW + 7) / 8;
	localparam int LB  = LOG_TABLE_BITS;

	logic [LOG2_FRAC-1:0] rom_w [2**LB];
	for (genvar g = 0; g < 2**LB; g++) begin : g_rom
		localparam logic [LOG2_FRAC-1:0] ENTRY = log2_frac(g, LB);
		assign rom_w[g] = ENTRY;
	end

	logic [NCH*8-1:0] qp;
	logic [NCH-1:0]   nz_c;
	logic [2:0]       pos_c [NCH];

	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	flags_t           fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6;
	logic [QW-1:0]    q_s1, q_s2;
	logic [NCH-1:0]   nz_s1;
	logic [2:0]       pos_s1 [NCH];
	logic [E_W-1:0]   e_c, e_s2, e_s3;
	logic [LB-1:0]    idx_c;
	logic [LOG2_FRAC-1:0] frac_s3;
	logic [E_W-1:0]   shamt;
	logic [QW-1:0]    shifted;
	logic signed [6:0]  ip;
	logic signed [30:0] l2;
	logic [LMAG_W-1:0]  mag_s4;
	logic               neg_s4, neg_s5, neg_s6;
	logic [59:0]        prod_s5;
	logic [59:0]        rnd;
	logic [LMAG_W-1:0]  ln_s6;

	// per-byte leading one
	always_comb begin
		qp = (NCH*8)'((in_q == '0) ? QW'(1) : in_q);
		for (int c = 0; c < NCH; c++) begin
			nz_c[c]  = |qp[c*8 +: 8];
			pos_c[c] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (qp[c*8 + b]) begin
					pos_c[c] = 3'(b);
				end
			end
		end
	end

	always_comb begin
		e_c = '0;
		for (int c = 0; c < NCH; c++) begin
			if (nz_s1[c]) begin
				e_c = E_W'(c * 8) + E_W'(pos_s1[c]);
			end
		end
		if (fl_s1.dz) begin
			e_c = '1;
		end
	end

	assign shamt   = E_W'(QW - 1) - e_s2;
	assign shifted = q_s2 << shamt;
	assign idx_c   = fl_s2.dz ? '1 : shifted[QW-2 -: LB];
	assign ip      = signed'({1'b0, e_s3}) - 7'(RATIO_FRAC_BITS);
	assign l2      = signed'({ip, frac_s3});
	assign rnd     = prod_s5 + 60'(64'd1 << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1    <= qp[QW-1:0];
			nz_s1   <= nz_c;
			pos_s1  <= pos_c;
			fl_s1   <= in_fl;
			q_s2    <= q_s1;
			e_s2    <= e_c;
			fl_s2   <= fl_s1;
			e_s3    <= e_s2;
			frac_s3 <= rom_w[idx_c];
			fl_s3   <= fl_s2;
			neg_s4  <= l2[30];
			mag_s4  <= l2[30] ? LMAG_W'(-l2) : l2[LMAG_W-1:0];
			fl_s4   <= fl_s3;
			prod_s5 <= 60'(mag_s4) * 60'(LN2_Q30);
			neg_s5  <= neg_s4;
			fl_s5   <= fl_s4;
			ln_s6   <= rnd[59:30];
			neg_s6  <= neg_s5;
			fl_s6   <= fl_s5;
		end
	end

	assign out_vld = vld_s6;
	assign ln_mag  = ln_s6;
	assign ln_neg  = neg_s6;
	assign out_fl  = fl_s6;

endmodule

FILE: sv/ntc_beta_temperature_top.sv
// ntc_beta_temperature_top: divider voltage to temperature by the beta equation
//
// sample channel: one voltage in millivolts per transaction; result channel:
// one signed temperature in hundredths of a degree Celsius plus a status code
// (ok, voltage invalid, saturated high) per sample, in sample order.
// configuration: write enable, register index and data; the user must write
// only while idle; the block itself does not enforce it. stages: two for the
// front end and multipliers, one per bit of the ratio quotient in the first
// divider, six in the log unit, four for the kelvin divisor, 17 in the kelvin
// divider and one output register.
// throughput: one sample per cycle while the receiver takes results.
// the whole pipeline moves as one; when the receiver stalls with a result
// waiting, every stage holds and sample ready falls, nothing is lost.
// reset clears all valid bits and loads the default register values;
// the block takes samples from the first cycle after reset.
module ntc_beta_temperature_top import ntcb_pkg::*; #(
	parameter int LOG_TABLE_BITS  = LOG_TABLE_BITS_DEF,
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	ntcb_in_if.sink              sample,
	ntcb_out_if.source           result
);

	localparam int QW = RNUM_W + RATIO_FRAC_BITS;

	logic [SUP_W-1:0]  supply_q;
	logic [OHM_W-1:0]  series_q;
	logic [OHM_W-1:0]  nominal_q;
	logic [BETA_W-1:0] beta_q;
	logic [T0_W-1:0]   t0_q;
	logic [29:0]       tb_q;
	logic [36:0]       numbase_q;
	logic [20:0]       base_q;

	logic en;

	logic              vld_s1, vld_s2;
	logic [V_W-1:0]    v_s1;
	logic              inv_s1, inv_s2;
	logic [RNUM_W-1:0] rnum_s2;
	logic [RDEN_W-1:0] rden_s2;
	flags_t            fl_f2;

	logic              dv1_vld;
	logic [QW-1:0]     dv1_q;
	flags_t            dv1_fl;

	logic              lg_vld;
	logic [LMAG_W-1:0] lg_mag;
	logic              lg_neg;
	flags_t            lg_fl;

	logic               vld_s3, vld_s4, vld_s5, vld_s6;
	logic [PT_W-1:0]    pt_s3;
	logic               neg_s3;
	flags_t             fl_s3, fl_s4, fl_s5, fl_s6;
	logic signed [TDEN_W-1:0] tden_c, tden_s4;
	logic [KDEN_W-1:0]  den_s5, den_s6;
	logic [KNUM_W-1:0]  num_s5, num_s6;
	logic               big;

	logic              dv2_vld;
	logic [KQ_W-1:0]   dv2_q;
	flags_t            dv2_fl;

	logic                     vld_s7;
	logic signed [TEMP_W-1:0] temp_s7;
	status_t                  st_s7;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q  <= SUP_W'(3300);
			series_q  <= OHM_W'(100000);
			nominal_q <= OHM_W'(100000);
			beta_q    <= BETA_W'(3950);
			t0_q      <= T0_W'(29815);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_SUPPLY:  supply_q  <= cfg_wdata[SUP_W-1:0];
				REG_SERIES:  series_q  <= cfg_wdata[OHM_W-1:0];
				REG_NOMINAL: nominal_q <= cfg_wdata[OHM_W-1:0];
				REG_BETA:    beta_q    <= cfg_wdata[BETA_W-1:0];
				REG_REF_T:   t0_q      <= cfg_wdata[T0_W-1:0];
				default: ;
			endcase
		end
	end

	// constants derived from the registers
	always_ff @(posedge clk) begin
		tb_q      <= 30'(t0_q) * 30'(beta_q);
		numbase_q <= 37'(tb_q) * 37'(100);
		base_q    <= 21'(beta_q) * 21'(100);
	end

	assign en           = !vld_s7 || result.ready;
	assign sample.ready = en;

	// front end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1    <= sample.tap_mv;
			inv_s1  <= (sample.tap_mv == '0) || (sample.tap_mv >= supply_q);
			rnum_s2 <= RNUM_W'(v_s1) * RNUM_W'(series_q);
			rden_s2 <= RDEN_W'(supply_q - v_s1) * RDEN_W'(nominal_q);
			inv_s2  <= inv_s1;
		end
	end

	assign fl_f2 = '{inv: inv_s2, dz: (rden_s2 == '0), sat: 1'b0};

	ntcb_div #(.DEN_W(RDEN_W), .Q_W(QW)) u_ratio_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (vld_s2),
		.in_rem ('0),
		.in_lo  ({rnum_s2, {RATIO_FRAC_BITS{1'b0}}}),
		.in_den (rden_s2),
		.in_fl  (fl_f2),
		.out_vld(dv1_vld),
		.out_q  (dv1_q),
		.out_fl (dv1_fl)
	);

	ntcb_log #(
		.LOG_TABLE_BITS (LOG_TABLE_BITS),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS),
		.QW             (QW)
	) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (dv1_vld),
		.in_q   (dv1_q),
		.in_fl  (dv1_fl),
		.out_vld(lg_vld),
		.ln_mag (lg_mag),
		.ln_neg (lg_neg),
		.out_fl (lg_fl)
	);

	// kelvin divisor and dividend
	assign tden_c = neg_s3 ? TDEN_W'(signed'({3'b0, base_q, 24'b0}) - signed'({2'b0, pt_s3}))
	                       : TDEN_W'(signed'({3'b0, base_q, 24'b0}) + signed'({2'b0, pt_s3}));
	assign big    = {2'b0, num_s5} >= {den_s5, 17'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s3 <= lg_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s3   <= PT_W'(lg_mag) * PT_W'(t0_q);
			neg_s3  <= lg_neg;
			fl_s3   <= lg_fl;
			tden_s4 <= tden_c;
			fl_s4   <= fl_s3;
			den_s5  <= tden_s4[KDEN_W-1:0];
			num_s5  <= KNUM_W'({numbase_q, 24'b0}) + KNUM_W'(tden_s4[KDEN_W-1:1]);
			fl_s5   <= '{inv: fl_s4.inv, dz: 1'b0,
			             sat: tden_s4[TDEN_W-1] || (tden_s4 == '0)};
			den_s6  <= den_s5;
			num_s6  <= num_s5;
			fl_s6   <= '{inv: fl_s5.inv, dz: 1'b0, sat: fl_s5.sat || big};
		end
	end

	// kelvin divider
	ntcb_div #(.DEN_W(KDEN_W), .Q_W(KQ_W)) u_kelvin_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (vld_s6),
		.in_rem (KDEN_W'(num_s6[KNUM_W-1:KQ_W])),
		.in_lo  (num_s6[KQ_W-1:0]),
		.in_den (den_s6),
		.in_fl  (fl_s6),
		.out_vld(dv2_vld),
		.out_q  (dv2_q),
		.out_fl (dv2_fl)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= dv2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (dv2_fl.inv) begin
				temp_s7 <= '0;
				st_s7   <= ST_INVALID;
			end else if (dv2_fl.sat || (dv2_q > KQ_W'(TK_MAX))) begin
				temp_s7 <= TEMP_W'(OUT_MAX);
				st_s7   <= ST_SAT;
			end else begin
				temp_s7 <= signed'(TEMP_W'(dv2_q - KQ_W'(ZERO_C_CENTIK)));
				st_s7   <= ST_OK;
			end
		end
	end

	assign result.valid        = vld_s7;
	assign result.temp_centi_c = temp_s7;
	assign result.status       = st_s7;

endmodule

FILE: test/testbench.sv
// testbench: checks ntc_beta_temperature_top against its own beta-equation predictor
module testbench;
	import ntcb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] UNUSED_IDX = 3'd6;
	localparam int LATENCY = 63 + RATIO_FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	ntcb_in_if sample ();
	ntcb_out_if result ();

	ntc_beta_temperature_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .sample(sample.sink), .result(result.source)
	);

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		status_t st;
	} reading_t;

	class temp_scoreboard;
		longint unsigned supply, series, nominal, beta, ref_t;
		logic [LOG2_FRAC-1:0] frac_rom [1 << LOG_TABLE_BITS_DEF];
		reading_t awaited [$];
		int errors, checked, n_ok, n_inv, n_sat;

		function new();
			longint unsigned x;
			supply = 3300;
			series = 100000;
			nominal = 100000;
			beta = 3950;
			ref_t = 29815;
			for (int i = 0; i < (1 << LOG_TABLE_BITS_DEF); i++) begin
				x = longint'((1 << LOG_TABLE_BITS_DEF) + i) << (30 - LOG_TABLE_BITS_DEF);
				frac_rom[i] = '0;
				for (int b = LOG2_FRAC - 1; b >= 0; b--) begin
					x = (x * x) >> 30;
					if (x >= (64'd2 << 30)) begin
						x = x >> 1;
						frac_rom[i][b] = 1'b1;
					end
				end
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_SUPPLY: supply = 64'(val[SUP_W-1:0]);
				REG_SERIES: series = 64'(val[OHM_W-1:0]);
				REG_NOMINAL: nominal = 64'(val[OHM_W-1:0]);
				REG_BETA: beta = 64'(val[BETA_W-1:0]);
				REG_REF_T: ref_t = 64'(val[T0_W-1:0]);
				default: ;
			endcase
		endfunction

		// works out the temperature that one voltage should give
		function void note(logic [V_W-1:0] v);
			reading_t r;
			longint unsigned rnum, rden, q, idx, mag, tnum, tk;
			longint l2, ln, tden;
			int e;
			if (v == 0 || v >= supply) begin
				r.temp = '0;
				r.st = ST_INVALID;
				awaited.push_back(r);
				return;
			end
			rnum = (longint'(v) * series) << RATIO_FRAC_BITS_DEF;
			rden = (supply - v) * nominal;
			q = (rden != 0) ? rnum / rden : 64'hFFFF_FFFF_FFFF_FFFF;
			if (q == 0)
				q = 1;
			e = 63;
			while (q[e] == 1'b0)
				e--;
			if (e >= LOG_TABLE_BITS_DEF)
				idx = (q >> (e - LOG_TABLE_BITS_DEF)) & ((1 << LOG_TABLE_BITS_DEF) - 1);
			else
				idx = (q << (LOG_TABLE_BITS_DEF - e)) & ((1 << LOG_TABLE_BITS_DEF) - 1);
			l2 = longint'(e - RATIO_FRAC_BITS_DEF) * (longint'(1) << LOG2_FRAC)
				+ longint'(frac_rom[idx]);
			mag = (l2 < 0) ? longint'(-l2) : longint'(l2);
			mag = (mag * longint'(LN2_Q30) + (longint'(1) << 29)) >> 30;
			ln = (l2 < 0) ? -longint'(mag) : longint'(mag);
			tden = longint'(100 * beta) * (longint'(1) << LOG2_FRAC) + ln * longint'(ref_t);
			if (tden <= 0) begin
				r.temp = TEMP_W'(OUT_MAX);
				r.st = ST_SAT;
			end else begin
				tnum = (100 * ref_t * beta) << LOG2_FRAC;
				tk = (tnum + longint'(tden) / 2) / longint'(tden);
				if (tk > TK_MAX) begin
					r.temp = TEMP_W'(OUT_MAX);
					r.st = ST_SAT;
				end else begin
					r.temp = TEMP_W'(longint'(tk) - ZERO_C_CENTIK);
					r.st = ST_OK;
				end
			end
			awaited.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check(logic signed [TEMP_W-1:0] temp, logic [ST_W-1:0] st);
			reading_t r;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result temp=%0d status=%0d", temp, st));
				return;
			end
			r = awaited.pop_front();
			checked++;
			if (temp !== r.temp)
				report($sformatf("temp_centi_c %0d, expected %0d", temp, r.temp));
			if (st !== r.st)
				report($sformatf("status %0d, expected %0d", st, r.st));
			case (r.st)
				ST_OK: n_ok++;
				ST_INVALID: n_inv++;
				default: n_sat++;
			endcase
		endtask
	endclass

	temp_scoreboard sb;
	bit hold_req;
	int idle_cycles;
	int sent;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver with its own stall pattern and one long hold-off on request
	initial begin
		int mode;
		int cyc;
		result.ready = 0;
		cyc = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result.valid && result.ready)
				sb.check(result.temp_centi_c, result.status);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 2);
			if (hold_req) begin
				result.ready <= 1'b0;
				repeat (LONG_HOLD - 1) begin
					@(posedge clk);
					if (result.valid && result.ready)
						sb.check(result.temp_centi_c, result.status);
				end
				hold_req = 0;
			end else begin
				case (mode)
					0: result.ready <= 1'b1;
					1: result.ready <= 1'($urandom_range(0, 1));
					default: result.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((sample.valid && sample.ready) || (result.valid && result.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic drain();
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_all(int sup, int ser, int nom, int bet, int t0);
		drain();
		cfg_write(REG_SUPPLY, CFG_W'(sup));
		cfg_write(REG_SERIES, CFG_W'(ser));
		cfg_write(REG_NOMINAL, CFG_W'(nom));
		cfg_write(REG_BETA, CFG_W'(bet));
		cfg_write(REG_REF_T, CFG_W'(t0));
	endtask

	// offers one voltage and waits for the transaction
	task automatic send(logic [V_W-1:0] v);
		sample.valid <= 1'b1;
		sample.tap_mv <= v;
		do
			@(posedge clk);
		while (!sample.ready);
		sb.note(v);
		sent++;
	endtask

	function automatic logic [V_W-1:0] pick_voltage();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return '0;
		if (k == 1)
			return V_W'($urandom_range(0, 8191));
		if (k == 2 && sb.supply <= 8191)
			return V_W'($urandom_range(sb.supply, 8191));
		if (sb.supply < 2)
			return V_W'($urandom_range(0, 8191));
		return V_W'($urandom_range(1, sb.supply > 8192 ? 8191 : sb.supply - 1));
	endfunction

	task automatic random_items(int n);
		int burst;
		int gap;
		while (n > 0) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && n > 0; i++) begin
				send(pick_voltage());
				n--;
			end
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
			if (gap > 0) begin
				sample.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		sample.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed(int sup);
		logic [V_W-1:0] pts [8];
		pts = '{V_W'(0), V_W'(1), V_W'(2), V_W'(sup / 2), V_W'(sup - 1), V_W'(sup),
			V_W'(8191), V_W'(4096)};
		foreach (pts[i])
			send(pts[i]);
		sample.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		sb = new();
		hold_req = 0;
		sent = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_wdata = '0;
		sample.valid = 0;
		sample.tap_mv = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed(3300);
		hold_req = 1;
		random_items(150);
		drain();
		random_items(60);

		// low supply, small series, large nominal, small beta and T0
		set_all(1000, 100, 1000000, 1000, 20000);
		directed(1000);
		random_items(100);

		// opposite extremes
		set_all(5000, 1000000, 100, 10000, 40000);
		directed(5000);
		random_items(100);

		// zero nominal makes the ratio saturate; the other register fields at their maximum
		set_all(8191, 1048575, 0, 16383, 65535);
		directed(8191);
		random_items(60);

		// zero supply and zero series; ignored index must change nothing
		set_all(0, 0, 100000, 3950, 29815);
		cfg_write(UNUSED_IDX, 20'hFFFFF);
		directed(0);
		random_items(30);

		repeat (4) begin
			set_all($urandom_range(1000, 5000), $urandom_range(100, 1000000),
				$urandom_range(100, 1000000), $urandom_range(1000, 10000),
				$urandom_range(20000, 40000));
			random_items(80);
		end

		drain();
		$display("%0d samples sent over 9 register settings, %0d results checked",
			sent, sb.checked);
		$display("ok %0d, invalid voltage %0d, saturated %0d", sb.n_ok, sb.n_inv, sb.n_sat);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
sv/ntcb_pkg.sv
sv/ntcb_in_if.sv
sv/ntcb_out_if.sv
sv/ntcb_div.sv
sv/ntcb_log.sv
sv/ntc_beta_temperature_top.sv
test/testbench.sv
